### rtl/ffa_pkg.sv
// Shared constants and codes for the first-fit byte allocator.
package ffa_pkg;

    // Default heap size in bytes
    localparam int unsigned HEAP_BYTES_DEF = 4096;

    // Fixed field widths
    localparam int unsigned TYPE_W   = 2;
    localparam int unsigned SIZE_W   = 13;
    localparam int unsigned ADDR_W   = 12;
    localparam int unsigned LEN_W    = 13;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LIVE_W   = 13;

    // Per-byte map marks
    localparam int unsigned MARK_W = 2;
    localparam logic [MARK_W-1:0] MARK_NONE  = 2'b00;
    localparam logic [MARK_W-1:0] MARK_OCC   = 2'b01;
    localparam logic [MARK_W-1:0] MARK_START = 2'b10;
    localparam logic [MARK_W-1:0] MARK_ANY   = 2'b11;

    // Live block counter saturates here
    localparam logic [LIVE_W-1:0] COUNT_MAX = 13'h1FFF;

    // Request types
    localparam logic [TYPE_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_QUERY   = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_CLEAR   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOOP    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPTR  = 2'd3;

endpackage

### rtl/ffa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ffa_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/first_fit_byte_allocator_core.sv
// First-fit byte allocator: byte map in RAM walked by a small sequencer.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+--------------------------------------------
//  request   | i_req_valid / o_req_ready | i_req_type i_req_size i_req_addr i_addr_present
//  result    | o_res_valid / i_res_ready | o_result_addr o_result_len o_status o_live_count
//
// Each request walks the map one byte per cycle: allocate scans to the end of the first
//   fitting run and then marks its bytes; release and size query walk the block to its
//   end, or stop at its first byte if that is no block start; clear zeroes the whole map;
//   zero size, oversize and null go straight to the result. Ready returns with the result.
// After reset a clearing pass over the whole map runs before the first request.
// A result not yet taken holds the next result in the response state, and the input off.
module first_fit_byte_allocator_core #(
    parameter int unsigned HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic [ffa_pkg::TYPE_W-1:0]    i_req_type,
    input  logic [ffa_pkg::SIZE_W-1:0]    i_req_size,
    input  logic [ffa_pkg::ADDR_W-1:0]    i_req_addr,
    input  logic                          i_addr_present,
    // result channel
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [ffa_pkg::ADDR_W-1:0]    o_result_addr,
    output logic [ffa_pkg::LEN_W-1:0]     o_result_len,
    output logic [ffa_pkg::STATUS_W-1:0]  o_status,
    output logic [ffa_pkg::LIVE_W-1:0]    o_live_count
);

    localparam int unsigned AW = $clog2(HEAP_BYTES);
    localparam int unsigned IW = AW + 1;
    localparam int unsigned SW = (IW > ffa_pkg::SIZE_W) ? IW : ffa_pkg::SIZE_W;
    localparam logic [IW-1:0] HEAP_END  = IW'(HEAP_BYTES);
    localparam logic [IW-1:0] HEAP_LAST = IW'(HEAP_BYTES - 1);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_MARK  = 6'b001000,
        ST_WALK  = 6'b010000,
        ST_RESP  = 6'b100000
    } t_state;

    // Sequencer state
    t_state                          r_state,  n_state;
    logic [ffa_pkg::TYPE_W-1:0]      r_type,   n_type;
    logic [IW-1:0]                   r_idx,    n_idx;
    logic [AW-1:0]                   r_pidx,   n_pidx;
    logic                            r_pend,   n_pend;
    logic                            r_first,  n_first;
    logic [IW-1:0]                   r_run,    n_run;
    logic [IW-1:0]                   r_size,   n_size;
    logic [AW-1:0]                   r_base,   n_base;
    logic [ffa_pkg::STATUS_W-1:0]    r_stat,   n_stat;
    logic [ffa_pkg::LIVE_W-1:0]      r_live,   n_live;
    logic                            r_clr_resp, n_clr_resp;

    // Output register
    logic                            r_out_valid, n_out_valid;
    logic [ffa_pkg::ADDR_W-1:0]      r_o_addr,    n_o_addr;
    logic [ffa_pkg::LEN_W-1:0]       r_o_len,     n_o_len;
    logic [ffa_pkg::STATUS_W-1:0]    r_o_stat,    n_o_stat;
    logic [ffa_pkg::LIVE_W-1:0]      r_o_live,    n_o_live;

    // Map RAM port signals
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [ffa_pkg::MARK_W-1:0]      ram_wdata;
    logic [ffa_pkg::MARK_W-1:0]      rd_data;

    // Walk and scan helpers
    logic                            byte_free;
    logic                            walk_cont;
    logic [IW-1:0]                   run_inc;
    logic [IW-1:0]                   hit_base;
    logic                            out_free;

    ffa_ram #(
        .WIDTH (ffa_pkg::MARK_W),
        .DEPTH (HEAP_BYTES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign byte_free = ((rd_data & ffa_pkg::MARK_ANY) == ffa_pkg::MARK_NONE);
    assign walk_cont = r_first ? ((rd_data & ffa_pkg::MARK_START) != ffa_pkg::MARK_NONE)
                               : ((rd_data & ffa_pkg::MARK_OCC) != ffa_pkg::MARK_NONE);
    assign run_inc   = r_run + IW'(1);
    assign hit_base  = {1'b0, r_pidx} + IW'(1) - r_size;
    assign out_free  = !r_out_valid || i_res_ready;

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_type     = r_type;
        n_idx      = r_idx;
        n_pidx     = r_pidx;
        n_pend     = r_pend;
        n_first    = r_first;
        n_run      = r_run;
        n_size     = r_size;
        n_base     = r_base;
        n_stat     = r_stat;
        n_live     = r_live;
        n_clr_resp = r_clr_resp;
        ram_we     = 1'b0;
        ram_waddr  = r_idx[AW-1:0];
        ram_wdata  = ffa_pkg::MARK_NONE;

        case (r_state)
            // zero the map one byte per cycle
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_idx  = r_idx + IW'(1);
                if (r_idx == HEAP_LAST) begin
                    n_live  = '0;
                    n_state = r_clr_resp ? ST_RESP : ST_IDLE;
                end
            end

            // take a request and sort out the early-out cases
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_type  = i_req_type;
                    n_pend  = 1'b0;
                    n_first = 1'b1;
                    n_run   = '0;
                    n_stat  = ffa_pkg::ST_OK;
                    case (i_req_type)
                        ffa_pkg::REQ_ALLOC: begin
                            if (i_req_size == '0) begin
                                n_stat  = ffa_pkg::ST_NOOP;
                                n_state = ST_RESP;
                            end else if (SW'(i_req_size) > SW'(HEAP_BYTES)) begin
                                n_stat  = ffa_pkg::ST_NOMEM;
                                n_state = ST_RESP;
                            end else begin
                                n_size  = IW'(i_req_size);
                                n_idx   = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        ffa_pkg::REQ_RELEASE, ffa_pkg::REQ_QUERY: begin
                            if (!i_addr_present) begin
                                n_stat  = ffa_pkg::ST_NOOP;
                                n_state = ST_RESP;
                            end else if (SW'(i_req_addr) >= SW'(HEAP_BYTES)) begin
                                n_stat  = ffa_pkg::ST_BADPTR;
                                n_state = ST_RESP;
                            end else begin
                                n_idx   = IW'(i_req_addr);
                                n_state = ST_WALK;
                            end
                        end
                        default: begin
                            n_idx      = '0;
                            n_clr_resp = 1'b1;
                            n_state    = ST_CLEAR;
                        end
                    endcase
                end
            end

            // first-fit search, one byte per cycle, read one ahead
            ST_SCAN: begin
                if (r_pend && byte_free && (run_inc == r_size)) begin
                    n_base  = hit_base[AW-1:0];
                    n_idx   = hit_base;
                    n_run   = r_size;
                    n_pend  = 1'b0;
                    n_state = ST_MARK;
                end else begin
                    if (r_pend) begin
                        n_run = byte_free ? run_inc : '0;
                    end
                    if (r_idx == HEAP_END) begin
                        n_pend  = 1'b0;
                        n_stat  = ffa_pkg::ST_NOMEM;
                        n_state = ST_RESP;
                    end else begin
                        n_pidx = r_idx[AW-1:0];
                        n_idx  = r_idx + IW'(1);
                        n_pend = 1'b1;
                    end
                end
            end

            // mark the found run: start byte, then occupied bytes
            ST_MARK: begin
                ram_we    = 1'b1;
                ram_wdata = (r_idx[AW-1:0] == r_base) ? ffa_pkg::MARK_START
                                                      : ffa_pkg::MARK_OCC;
                n_idx     = r_idx + IW'(1);
                n_run     = r_run - IW'(1);
                if (r_run == IW'(1)) begin
                    if (r_live != ffa_pkg::COUNT_MAX) begin
                        n_live = r_live + ffa_pkg::LIVE_W'(1);
                    end
                    n_stat  = ffa_pkg::ST_OK;
                    n_state = ST_RESP;
                end
            end

            // block walk for release and size query
            ST_WALK: begin
                if (r_pend && !walk_cont) begin
                    n_pend  = 1'b0;
                    n_state = ST_RESP;
                    if (r_first) begin
                        n_stat = ffa_pkg::ST_BADPTR;
                    end else if (r_type == ffa_pkg::REQ_RELEASE && r_live != '0) begin
                        n_live = r_live - ffa_pkg::LIVE_W'(1);
                    end
                end else begin
                    if (r_pend) begin
                        ram_we    = (r_type == ffa_pkg::REQ_RELEASE);
                        ram_waddr = r_pidx;
                        n_run     = run_inc;
                        n_first   = 1'b0;
                    end
                    if (r_pend && r_idx == HEAP_END) begin
                        n_pend  = 1'b0;
                        n_state = ST_RESP;
                        if (r_type == ffa_pkg::REQ_RELEASE && r_live != '0) begin
                            n_live = r_live - ffa_pkg::LIVE_W'(1);
                        end
                    end else begin
                        n_pidx = r_idx[AW-1:0];
                        n_idx  = r_idx + IW'(1);
                        n_pend = 1'b1;
                    end
                end
            end

            // hand the result to the output register
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register load
    always_comb begin
        n_out_valid = r_out_valid && !i_res_ready;
        n_o_addr    = r_o_addr;
        n_o_len     = r_o_len;
        n_o_stat    = r_o_stat;
        n_o_live    = r_o_live;
        if (r_state == ST_RESP && out_free) begin
            n_out_valid = 1'b1;
            n_o_stat    = r_stat;
            n_o_live    = r_live;
            n_o_addr    = (r_type == ffa_pkg::REQ_ALLOC && r_stat == ffa_pkg::ST_OK)
                          ? ffa_pkg::ADDR_W'(r_base) : '0;
            n_o_len     = (r_type == ffa_pkg::REQ_QUERY && r_stat == ffa_pkg::ST_OK)
                          ? ffa_pkg::LEN_W'(r_run) : '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_live      <= '0;
            r_clr_resp  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_live      <= n_live;
            r_clr_resp  <= n_clr_resp;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_type   <= n_type;
        r_pidx   <= n_pidx;
        r_first  <= n_first;
        r_run    <= n_run;
        r_size   <= n_size;
        r_base   <= n_base;
        r_stat   <= n_stat;
        r_o_addr <= n_o_addr;
        r_o_len  <= n_o_len;
        r_o_stat <= n_o_stat;
        r_o_live <= n_o_live;
    end

    assign o_req_ready   = (r_state == ST_IDLE);
    assign o_res_valid   = r_out_valid;
    assign o_result_addr = r_o_addr;
    assign o_result_len  = r_o_len;
    assign o_status      = r_o_stat;
    assign o_live_count  = r_o_live;

    // Map writes only come from the clear pass, marking or a release walk
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_CLEAR || r_state == ST_MARK || r_state == ST_WALK))
        else $error("map write outside clear, mark or walk");

    // A run under way never reaches the requested size without a hit
    a_scan_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_run < r_size))
        else $error("scan run reached request size");

    // Marking always has bytes left to write
    a_mark_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MARK) |-> (r_run != '0))
        else $error("mark phase with nothing left");

    // An accepted request always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("still ready after accepting a request");

endmodule

### test/ffa_checker.sv
// Scoreboard for the first-fit allocator: tracks the heap map and checks every result.
module ffa_checker #(
    parameter int unsigned HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  logic [ffa_pkg::TYPE_W-1:0]    i_req_type,
    input  logic [ffa_pkg::SIZE_W-1:0]    i_req_size,
    input  logic [ffa_pkg::ADDR_W-1:0]    i_req_addr,
    input  logic                          i_addr_present,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic [ffa_pkg::ADDR_W-1:0]    i_result_addr,
    input  logic [ffa_pkg::LEN_W-1:0]     i_result_len,
    input  logic [ffa_pkg::STATUS_W-1:0]  i_status,
    input  logic [ffa_pkg::LIVE_W-1:0]    i_live_count,
    output int                            o_fail_count,
    output int                            o_pending,
    output logic [HEAP_BYTES-1:0]         o_block_starts
);
    import ffa_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [LEN_W-1:0]    len;
        logic [STATUS_W-1:0] status;
        logic [LIVE_W-1:0]   live;
    } t_alloc_result;

    // shadow copy of the heap map and block counter
    logic [MARK_W-1:0] heap_marks [HEAP_BYTES];
    logic [LIVE_W-1:0] live_blocks;
    t_alloc_result     outstanding_q [$];
    int                mismatches;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(string what, int unsigned got_v, int unsigned want_v);
        if (mismatches < 100) begin
            $display("checker: %s got %0d expected %0d at %0t", what, got_v, want_v, $time);
        end
        mismatches++;
    endtask

    // length of the block starting at a, stopping at the heap end
    function automatic int unsigned block_length(int unsigned a);
        int unsigned n;
        n = 1;
        while (a + n < HEAP_BYTES && (heap_marks[a + n] & MARK_OCC) != MARK_NONE) n++;
        return n;
    endfunction

    function automatic bool_is_start(int unsigned a);
        return a < HEAP_BYTES && (heap_marks[a] & MARK_START) != MARK_NONE;
    endfunction

    // apply one request to the shadow map and return the result it must produce
    function automatic t_alloc_result apply_request(logic [TYPE_W-1:0] kind,
                                                    logic [SIZE_W-1:0] size,
                                                    logic [ADDR_W-1:0] addr,
                                                    logic present);
        t_alloc_result r;
        int unsigned   run, base, len;
        bit            found;
        r = '0;
        r.status = ST_OK;
        case (kind)
            REQ_ALLOC: begin
                if (size == '0) begin
                    r.status = ST_NOOP;
                end else if (int'(size) > HEAP_BYTES) begin
                    r.status = ST_NOMEM;
                end else begin
                    run   = 0;
                    base  = 0;
                    found = 1'b0;
                    for (int unsigned i = 0; i < HEAP_BYTES && !found; i++) begin
                        if (heap_marks[i] != MARK_NONE) begin
                            run = 0;
                        end else begin
                            run++;
                            if (run == size) begin
                                base  = i + 1 - size;
                                found = 1'b1;
                            end
                        end
                    end
                    if (found) begin
                        heap_marks[base] |= MARK_START;
                        for (int unsigned k = 1; k < size; k++) heap_marks[base + k] |= MARK_OCC;
                        if (live_blocks < COUNT_MAX) live_blocks++;
                        r.addr = ADDR_W'(base);
                    end else begin
                        r.status = ST_NOMEM;
                    end
                end
            end
            REQ_RELEASE: begin
                if (!present) begin
                    r.status = ST_NOOP;
                end else if (!bool_is_start(addr)) begin
                    r.status = ST_BADPTR;
                end else begin
                    len = block_length(addr);
                    for (int unsigned k = 0; k < len; k++) heap_marks[addr + k] = MARK_NONE;
                    if (live_blocks != '0) live_blocks--;
                end
            end
            REQ_QUERY: begin
                if (!present) r.status = ST_NOOP;
                else if (!bool_is_start(addr)) r.status = ST_BADPTR;
                else r.len = LEN_W'(block_length(addr));
            end
            default: begin
                for (int unsigned k = 0; k < HEAP_BYTES; k++) heap_marks[k] = MARK_NONE;
                live_blocks = '0;
            end
        endcase
        r.live = live_blocks;
        return r;
    endfunction

    // watch both channels; results are retired before the new request is predicted
    always @(posedge i_clk) begin : watch
        t_alloc_result         seen, want;
        logic [HEAP_BYTES-1:0] starts_now;
        if (!i_rst_n) begin
            for (int unsigned k = 0; k < HEAP_BYTES; k++) heap_marks[k] = MARK_NONE;
            live_blocks = '0;
            outstanding_q.delete();
            o_pending      <= 0;
            o_block_starts <= '0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                seen = '{i_result_addr, i_result_len, i_status, i_live_count};
                if (outstanding_q.size() == 0) begin
                    report_mismatch("result with no request outstanding, status",
                                    seen.status, 0);
                end else begin
                    want = outstanding_q.pop_front();
                    if (seen.addr != want.addr)
                        report_mismatch("result_addr", seen.addr, want.addr);
                    if (seen.len != want.len)
                        report_mismatch("result_len", seen.len, want.len);
                    if (seen.status != want.status)
                        report_mismatch("status", seen.status, want.status);
                    if (seen.live != want.live)
                        report_mismatch("live_count", seen.live, want.live);
                end
            end
            if (i_req_valid && i_req_ready) begin
                outstanding_q.push_back(apply_request(i_req_type, i_req_size,
                                                      i_req_addr, i_addr_present));
                for (int unsigned k = 0; k < HEAP_BYTES; k++)
                    starts_now[k] = (heap_marks[k] & MARK_START) != MARK_NONE;
                o_block_starts <= starts_now;
            end
            o_pending <= outstanding_q.size();
        end
    end

endmodule

### test/testbench.sv
// Top of the allocator testbench: clock, reset, request stimulus and the verdict.
module testbench;
    import ffa_pkg::*;

    localparam int unsigned HEAP = HEAP_BYTES_DEF;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    logic [TYPE_W-1:0]   req_type;
    logic [SIZE_W-1:0]   req_size;
    logic [ADDR_W-1:0]   req_addr;
    logic                addr_present;
    logic                res_valid;
    logic                res_ready;
    logic [ADDR_W-1:0]   result_addr;
    logic [LEN_W-1:0]    result_len;
    logic [STATUS_W-1:0] status;
    logic [LIVE_W-1:0]   live_count;

    int                  fail_count;
    int                  pending;
    logic [HEAP-1:0]     live_starts;

    // receiver behavior, set per phase
    int unsigned         stall_pct;
    bit                  long_hold;

    first_fit_byte_allocator_core #(.HEAP_BYTES(HEAP)) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (req_valid),
        .o_req_ready    (req_ready),
        .i_req_type     (req_type),
        .i_req_size     (req_size),
        .i_req_addr     (req_addr),
        .i_addr_present (addr_present),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_result_addr  (result_addr),
        .o_result_len   (result_len),
        .o_status       (status),
        .o_live_count   (live_count)
    );

    ffa_checker #(.HEAP_BYTES(HEAP)) chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (req_valid),
        .i_req_ready    (req_ready),
        .i_req_type     (req_type),
        .i_req_size     (req_size),
        .i_req_addr     (req_addr),
        .i_addr_present (addr_present),
        .i_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .i_result_addr  (result_addr),
        .i_result_len   (result_len),
        .i_status       (status),
        .i_live_count   (live_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_block_starts (live_starts)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop if the block hangs
    initial begin
        #(64'd12 * 64'd40_000_000);
        $display("TB_ERROR");
        $finish;
    end

    // result side: random stalls, plus one long hold-off when asked
    initial begin
        res_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold) begin
                res_ready <= 1'b0;
                repeat (3000) @(posedge clk);
                long_hold = 1'b0;
            end else begin
                res_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // offer one request and hold it until taken
    task automatic send_request(logic [TYPE_W-1:0] kind, logic [SIZE_W-1:0] size,
                                logic [ADDR_W-1:0] addr, logic present);
        req_valid    <= 1'b1;
        req_type     <= kind;
        req_size     <= size;
        req_addr     <= addr;
        addr_present <= present;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // random live block start, or -1 when the heap holds none
    function automatic int random_start(output int unsigned n_live);
        int unsigned first_at, idx;
        int          found;
        n_live   = 0;
        found    = -1;
        first_at = $urandom_range(HEAP - 1);
        for (int unsigned k = 0; k < HEAP; k++) begin
            idx = (first_at + k) % HEAP;
            if (live_starts[idx]) begin
                n_live++;
                if (found < 0) found = idx;
            end
        end
        return found;
    endfunction

    // mostly well-formed traffic: allocs balanced against releases of live blocks
    task automatic random_request();
        int unsigned       n_live, roll, alloc_pct;
        int                at;
        logic [SIZE_W-1:0] sz;
        logic [TYPE_W-1:0] kind;
        at        = random_start(n_live);
        alloc_pct = (n_live > 40) ? 25 : ((n_live < 8) ? 60 : 40);
        roll      = $urandom_range(99);
        if (roll < alloc_pct) begin
            roll = $urandom_range(99);
            if (roll < 2) sz = '0;
            else if (roll < 4) sz = SIZE_W'($urandom_range(HEAP + 1, 8191));
            else if (roll < 6) sz = SIZE_W'($urandom_range(513, HEAP));
            else if (roll < 20) sz = SIZE_W'($urandom_range(65, 512));
            else sz = SIZE_W'($urandom_range(1, 64));
            send_request(REQ_ALLOC, sz, ADDR_W'($urandom), 1'($urandom));
        end else if (roll == 99) begin
            send_request(REQ_CLEAR, SIZE_W'($urandom), ADDR_W'($urandom), 1'($urandom));
        end else begin
            kind = ($urandom_range(99) < 60) ? REQ_RELEASE : REQ_QUERY;
            if (at >= 0 && $urandom_range(99) < 85)
                send_request(kind, SIZE_W'($urandom), ADDR_W'(at), 1'b1);
            else
                send_request(kind, SIZE_W'($urandom), ADDR_W'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_phase(int unsigned idle_pct, int unsigned stall, int unsigned n_items,
                             bit with_hold);
        stall_pct = stall;
        if (with_hold) long_hold = 1'b1;
        for (int unsigned i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < idle_pct) begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            random_request();
        end
        drain();
    endtask

    // main sequence
    initial begin
        stall_pct = 0;
        long_hold = 1'b0;
        rst_n        <= 1'b0;
        req_valid    <= 1'b0;
        req_type     <= REQ_ALLOC;
        req_size     <= '0;
        req_addr     <= '0;
        addr_present <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: no-ops, oversize, full heap, heap-end walk, first fit into a hole
        send_request(REQ_ALLOC,   13'd0,    12'd0,    1'b1);
        send_request(REQ_ALLOC,   13'd4097, 12'd0,    1'b1);
        send_request(REQ_ALLOC,   13'd8191, 12'hFFF,  1'b0);
        send_request(REQ_RELEASE, 13'd0,    12'hFFF,  1'b0);
        send_request(REQ_QUERY,   13'h1FFF, 12'd0,    1'b0);
        send_request(REQ_ALLOC,   13'd4096, 12'd0,    1'b1);
        send_request(REQ_ALLOC,   13'd1,    12'd0,    1'b1);
        send_request(REQ_QUERY,   13'd0,    12'd0,    1'b1);
        send_request(REQ_QUERY,   13'd0,    12'hFFF,  1'b1);
        send_request(REQ_RELEASE, 13'd0,    12'd0,    1'b1);
        send_request(REQ_ALLOC,   13'd4000, 12'd0,    1'b1);
        send_request(REQ_ALLOC,   13'd96,   12'd0,    1'b1);
        send_request(REQ_QUERY,   13'd0,    12'd4000, 1'b1);
        send_request(REQ_ALLOC,   13'd1,    12'd0,    1'b1);
        send_request(REQ_RELEASE, 13'd0,    12'd0,    1'b1);
        send_request(REQ_ALLOC,   13'd10,   12'd0,    1'b1);
        send_request(REQ_ALLOC,   13'd20,   12'd0,    1'b1);
        send_request(REQ_RELEASE, 13'd0,    12'd0,    1'b1);
        send_request(REQ_ALLOC,   13'd5,    12'd0,    1'b1);
        send_request(REQ_ALLOC,   13'd6,    12'd0,    1'b1);
        send_request(REQ_QUERY,   13'd0,    12'd10,   1'b1);
        send_request(REQ_RELEASE, 13'd0,    12'd4000, 1'b1);
        send_request(REQ_RELEASE, 13'd0,    12'd4000, 1'b1);
        send_request(REQ_CLEAR,   13'h1FFF, 12'hFFF,  1'b1);
        send_request(REQ_QUERY,   13'd0,    12'd0,    1'b1);
        drain();

        // random traffic under different flow-control patterns
        run_phase(0,  0,  250, 1'b0);
        run_phase(70, 0,  250, 1'b0);
        run_phase(0,  70, 250, 1'b1);
        run_phase(12, 12, 250, 1'b0);

        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/ffa_pkg.sv
rtl/ffa_ram.sv
rtl/first_fit_byte_allocator_core.sv
test/ffa_checker.sv
test/testbench.sv
